@@ rtl/serial_variable_write_parser_assert.svh @@
// Assertion macros used by the parser RTL.
`ifndef SERIAL_VARIABLE_WRITE_PARSER_ASSERT_SVH
`define SERIAL_VARIABLE_WRITE_PARSER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SVWP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SVWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/svwp_pkg.sv @@
// Package: character codes, limits and widths of the variable write parser.
package svwp_pkg;

    localparam int unsigned MAX_VALUE_CHARS = 8;
    localparam int unsigned CHARS_W = $clog2(MAX_VALUE_CHARS + 1);

    localparam int unsigned ACC_W  = 27;
    localparam int unsigned PROD_W = ACC_W + 4;
    localparam int unsigned MANT_W = 28;

    localparam logic [PROD_W-1:0] MAG_LIMIT  = PROD_W'(99999999);
    localparam logic [2:0]        FRAC_LIMIT = 3'd7;

    localparam logic [7:0] CH_START  = 8'h21;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_END    = 8'h24;
    localparam logic [7:0] CH_ABORT  = 8'h43;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

@@ rtl/serial_variable_write_parser.sv @@
// Top level: streaming parser for '!' type index '=' value '$' write packets.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------
//  rx      | in        | rx_valid/rx_stall  | rx_byte (one received byte)
//  wr      | out       | wr_valid/wr_stall  | var_index, mantissa, frac_digits
//
// One byte is taken every cycle unless a '$' is held for a stalled result; the rate
// is set by the combinational parser update (phase, multiply-by-ten accumulator) between
// the byte register and the result register, which loads as the closing '$' moves on.
// Reset (rst_n low, asynchronous) returns the parser to waiting for '!'.
// A stalled result holds in its register; the byte register keeps taking
// bytes that yield no result, and holds only a '$' that would emit.
`include "serial_variable_write_parser_assert.svh"

module serial_variable_write_parser
    import svwp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rx_valid,
    output logic                     rx_stall,
    input  logic [7:0]               rx_byte,
    output logic                     wr_valid,
    input  logic                     wr_stall,
    output logic [3:0]               var_index,
    output logic signed [MANT_W-1:0] mantissa,
    output logic [2:0]               frac_digits
);

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_INDEX   = 3'd2,
        PH_EQ      = 3'd3,
        PH_FIRST   = 3'd4,
        PH_VALUE   = 3'd5,
        PH_DISCARD = 3'd6
    } phase_t;

    // Byte register.
    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         s1_byte_reg;

    // Parser state.
    phase_t             phase_reg, phase_next;
    logic [3:0]         index_reg, index_next;
    logic [ACC_W-1:0]   accum_reg, accum_next;
    logic               neg_reg, neg_next;
    logic               point_reg, point_next;
    logic [2:0]         dap_reg, dap_next;
    logic [CHARS_W-1:0] chars_reg, chars_next;
    logic               stopped_reg, stopped_next;

    // Result register.
    logic               wr_valid_reg, wr_valid_next;
    logic [3:0]         var_index_reg;
    logic [MANT_W-1:0]  mantissa_reg;
    logic [2:0]         frac_digits_reg;

    logic               emit;
    logic               out_free;
    logic               advance;
    logic               rx_take;
    logic [PROD_W-1:0]  times_ten;
    logic [MANT_W-1:0]  mag_ext;

    // Magnitude times ten plus the digit, for the overflow check.
    assign times_ten = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                     + PROD_W'(s1_byte_reg - CH_ZERO);

    // Advance the phase on each byte and fold value characters into the accumulator; past the limit, drop them.
    always_comb
    begin
        accum_next   = accum_reg;
        neg_next     = neg_reg;
        point_next   = point_reg;
        dap_next     = dap_reg;
        chars_next   = chars_reg;
        stopped_next = stopped_reg;
        phase_next   = phase_reg;
        index_next   = index_reg;
        emit         = 1'b0;

        if (s1_byte_reg == CH_ABORT)
        begin
            phase_next = PH_WAIT;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_TYPE:
                begin
                    phase_next = (s1_byte_reg == CH_END) ? PH_WAIT : PH_INDEX;
                end
                PH_INDEX:
                begin
                    if (s1_byte_reg == CH_END)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else if (is_digit(s1_byte_reg))
                    begin
                        index_next = 4'(s1_byte_reg - CH_ZERO);
                        phase_next = PH_EQ;
                    end
                    else
                    begin
                        phase_next = PH_DISCARD;
                    end
                end
                PH_EQ:
                begin
                    if (s1_byte_reg == CH_END)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else if (s1_byte_reg == CH_EQUALS)
                    begin
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        phase_next = PH_DISCARD;
                    end
                end
                PH_FIRST, PH_VALUE:
                begin
                    if (s1_byte_reg == CH_END)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_WAIT;
                    end
                    else if (phase_reg == PH_FIRST && s1_byte_reg == CH_QUERY)
                    begin
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                        if (chars_reg < CHARS_W'(MAX_VALUE_CHARS))
                        begin
                            if (!stopped_reg)
                            begin
                                if (is_digit(s1_byte_reg))
                                begin
                                    if (times_ten > MAG_LIMIT
                                        || (point_reg && dap_reg >= FRAC_LIMIT))
                                    begin
                                        stopped_next = 1'b1;
                                    end
                                    else
                                    begin
                                        accum_next = times_ten[ACC_W-1:0];
                                        dap_next   = dap_reg + {2'd0, point_reg};
                                    end
                                end
                                else if (s1_byte_reg == CH_POINT && !point_reg)
                                begin
                                    point_next = 1'b1;
                                end
                                else if ((s1_byte_reg == CH_MINUS
                                          || s1_byte_reg == CH_PLUS)
                                         && chars_reg == '0)
                                begin
                                    neg_next = (s1_byte_reg == CH_MINUS);
                                end
                                else
                                begin
                                    stopped_next = 1'b1;
                                end
                            end
                            chars_next = chars_reg + 1'b1;
                        end
                    end
                end
                PH_DISCARD:
                begin
                    if (s1_byte_reg == CH_END)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                default:
                begin
                    // Waiting for '!'; the unused code behaves the same.
                    if (s1_byte_reg == CH_START)
                    begin
                        accum_next   = '0;
                        neg_next     = 1'b0;
                        point_next   = 1'b0;
                        dap_next     = '0;
                        chars_next   = '0;
                        stopped_next = 1'b0;
                        index_next   = '0;
                        phase_next   = PH_TYPE;
                    end
                    else if (s1_byte_reg == CH_END)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_DISCARD;
                    end
                end
            endcase
        end
    end

    // Advance the byte unless it would emit into a full, stalled result register.
    assign out_free = !wr_valid_reg || !wr_stall;
    assign advance  = s1_valid_reg && (out_free || !emit);
    assign rx_stall = s1_valid_reg && !advance;
    assign rx_take  = rx_valid && !rx_stall;

    always_comb
    begin
        if (rx_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance && emit)
        begin
            wr_valid_next = 1'b1;
        end
        else if (!wr_stall)
        begin
            wr_valid_next = 1'b0;
        end
        else
        begin
            wr_valid_next = wr_valid_reg;
        end
    end

    assign mag_ext = {1'b0, accum_reg};

    // State, byte register and result register: load the byte, load the result on emit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_byte_reg     <= '0;
            wr_valid_reg    <= 1'b0;
            var_index_reg   <= '0;
            mantissa_reg    <= '0;
            frac_digits_reg <= '0;
            phase_reg       <= PH_WAIT;
            index_reg       <= '0;
            accum_reg       <= '0;
            neg_reg         <= 1'b0;
            point_reg       <= 1'b0;
            dap_reg         <= '0;
            chars_reg       <= '0;
            stopped_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            wr_valid_reg <= wr_valid_next;
            if (rx_take)
            begin
                s1_byte_reg <= rx_byte;
            end
            if (advance && emit)
            begin
                var_index_reg   <= index_reg;
                mantissa_reg    <= neg_reg ? (MANT_W'(0) - mag_ext) : mag_ext;
                frac_digits_reg <= dap_reg;
            end
            if (advance)
            begin
                phase_reg   <= phase_next;
                index_reg   <= index_next;
                accum_reg   <= accum_next;
                neg_reg     <= neg_next;
                point_reg   <= point_next;
                dap_reg     <= dap_next;
                chars_reg   <= chars_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    assign wr_valid    = wr_valid_reg;
    assign var_index   = var_index_reg;
    assign mantissa    = signed'(mantissa_reg);
    assign frac_digits = frac_digits_reg;

    `SVWP_ASSERT_NEXT(a_byte_hold, s1_valid_reg && rx_stall,
        s1_valid_reg && $stable(s1_byte_reg), "held byte lost or changed")
    `SVWP_ASSERT_NEXT(a_emit_resets, advance && emit,
        phase_reg == PH_WAIT && wr_valid_reg, "emit did not load result or rearm")
    `SVWP_ASSERT_ALWAYS(a_mag_limit, {4'd0, accum_reg} <= MAG_LIMIT,
        "accumulated magnitude above limit")
    `SVWP_ASSERT_ALWAYS(a_frac_point, dap_reg == '0 || point_reg,
        "fraction digits counted without a point")

endmodule

@@ tb/serial_variable_write_parser_test.sv @@
// Testbench for the variable write parser: table-driven packets, then random byte streams.
`timescale 1ns / 1ps

module serial_variable_write_parser_test
    import svwp_pkg::*;
();

    localparam int RANDOM_WORDS = 1030;  // rough length of the random byte stream
    localparam int CALM_WORDS   = 150;   // tail of the stream run with no idling at all
    localparam int QUIET_LIMIT  = 1000;  // cycles with no word moving on either channel
    localparam int DRAIN_CYCLES = 10;    // result passes the byte and result registers after '$'; leave slack
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_ROWS     = 25;

    typedef enum logic [2:0] {
        PH_WAIT, PH_TYPE, PH_INDEX, PH_EQ, PH_FIRST, PH_VALUE, PH_DISCARD
    } phase_t;

    // How a table row is checked: by the local parser, against a typed-in write,
    // or with no write at all.
    typedef enum logic [1:0] {
        ROW_PREDICT, ROW_WRITE, ROW_SILENT
    } row_kind_t;

    typedef struct packed {
        logic [3:0]               idx;
        logic signed [MANT_W-1:0] mant;
        logic [2:0]               frac;
    } write_t;

    typedef struct {
        string     text;
        row_kind_t kind;
        write_t    typed;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     rx_valid = 1'b0;
    logic                     rx_stall;
    logic [7:0]               rx_byte = 8'h00;
    logic                     wr_valid;
    logic                     wr_stall = 1'b0;
    logic [3:0]               var_index;
    logic signed [MANT_W-1:0] mantissa;
    logic [2:0]               frac_digits;

    // Side data that travels with each rx word so the checker knows how to treat it.
    row_kind_t byte_kind  = ROW_PREDICT;
    write_t    byte_typed = '0;

    serial_variable_write_parser uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .wr_valid    (wr_valid),
        .wr_stall    (wr_stall),
        .var_index   (var_index),
        .mantissa    (mantissa),
        .frac_digits (frac_digits)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local parser: tracks the packet phase and the value conversion
    // ------------------------------------------------------------------
    phase_t           phase_now   = PH_WAIT;
    logic [3:0]       idx_held    = '0;
    logic [ACC_W-1:0] mag_acc     = '0;
    logic             minus_seen  = 1'b0;
    logic             point_seen  = 1'b0;
    logic [2:0]       frac_count  = '0;
    logic [3:0]       value_chars = '0;
    logic             conv_halted = 1'b0;

    write_t pending_writes[$];  // writes the parser owes, oldest first
    int     failures = 0;

    // Fold one value character into the running conversion (atof style, no exponent).
    function automatic void take_value_char(input logic [7:0] c);
        logic [31:0] next_mag;
        // Characters past the value field width are ignored until '$'.
        if (value_chars >= MAX_VALUE_CHARS)
            return;
        if (!conv_halted)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                next_mag = 32'(mag_acc) * 32'd10 + 32'(c - CH_ZERO);
                if (next_mag > 32'(MAG_LIMIT) || (point_seen && frac_count >= FRAC_LIMIT))
                    conv_halted = 1'b1;
                else
                begin
                    mag_acc = ACC_W'(next_mag);
                    if (point_seen)
                        frac_count = frac_count + 3'd1;
                end
            end
            else if (c == CH_POINT && !point_seen)
                point_seen = 1'b1;
            else if ((c == CH_MINUS || c == CH_PLUS) && value_chars == 4'd0)
                minus_seen = (c == CH_MINUS);
            else
                conv_halted = 1'b1;
        end
        value_chars = value_chars + 4'd1;
    endfunction

    // Advance the parser by one received byte; return 1 when a write comes out.
    function automatic logic parse_byte(input logic [7:0] c, output write_t w);
        w = '0;
        // Abort byte drops the packet from any phase.
        if (c == CH_ABORT)
        begin
            phase_now = PH_WAIT;
            return 1'b0;
        end
        case (phase_now) inside
            PH_TYPE:
                phase_now = (c == CH_END) ? PH_WAIT : PH_INDEX;
            PH_INDEX:
                if (c == CH_END)
                    phase_now = PH_WAIT;
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    idx_held  = 4'(c - CH_ZERO);
                    phase_now = PH_EQ;
                end
                else
                    phase_now = PH_DISCARD;
            PH_EQ:
                if (c == CH_END)
                    phase_now = PH_WAIT;
                else
                    phase_now = (c == CH_EQUALS) ? PH_FIRST : PH_DISCARD;
            PH_FIRST, PH_VALUE:
                if (c == CH_END)
                begin
                    // Negative zero comes out as plain zero through the negate.
                    w.idx  = idx_held;
                    w.mant = minus_seen ? -MANT_W'(mag_acc) : MANT_W'(mag_acc);
                    w.frac = frac_count;
                    phase_now = PH_WAIT;
                    return 1'b1;
                end
                else if (phase_now == PH_FIRST && c == CH_QUERY)
                    phase_now = PH_DISCARD;
                else
                begin
                    take_value_char(c);
                    phase_now = PH_VALUE;
                end
            PH_DISCARD:
                if (c == CH_END)
                    phase_now = PH_WAIT;
            default:
                if (c == CH_START)
                begin
                    mag_acc     = '0;
                    minus_seen  = 1'b0;
                    point_seen  = 1'b0;
                    frac_count  = '0;
                    value_chars = '0;
                    conv_halted = 1'b0;
                    idx_held    = '0;
                    phase_now   = PH_TYPE;
                end
                else if (c != CH_END)
                    phase_now = PH_DISCARD;
        endcase
        return 1'b0;
    endfunction

    task automatic note_failure(input string what, input write_t want);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s: expected idx %0d mant %0d frac %0d, got idx %0d mant %0d frac %0d",
                     $time, what, want.idx, $signed(want.mant), want.frac,
                     var_index, mantissa, frac_digits);
    endtask

    // ------------------------------------------------------------------
    // Checker: predict on every accepted rx word, compare every wr word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        write_t predicted;
        write_t oldest;
        logic   emits;
        if (rst_n && rx_valid && !rx_stall)
        begin
            emits = parse_byte(rx_byte, predicted);
            case (byte_kind)
                // Typed rows carry their write on the closing '$'.
                ROW_WRITE:  if (rx_byte == CH_END) pending_writes.push_back(byte_typed);
                ROW_SILENT: ;
                default:    if (emits) pending_writes.push_back(predicted);
            endcase
        end
        if (rst_n && wr_valid && !wr_stall)
        begin
            if (pending_writes.size() == 0)
                note_failure("write with nothing pending", '0);
            else
            begin
                oldest = pending_writes.pop_front();
                if (oldest.idx !== var_index || oldest.mant !== mantissa
                    || oldest.frac !== frac_digits)
                    note_failure("write mismatch", oldest);
            end
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && !rx_stall) || (wr_valid && !wr_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL serial_variable_write_parser");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: random stall bursts
    // ------------------------------------------------------------------
    int   idle_pct   = 20;
    int   stall_pct  = 20;
    logic calm       = 1'b0;
    int   stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            wr_stall   <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 4);
            wr_stall   <= 1'b1;
        end
        else
            wr_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------

    // Offer one rx word, after an optional idle burst, and hold it until taken.
    task automatic send_byte(input logic [7:0] b, input row_kind_t k, input write_t w);
        int gap;
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 5);
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid   <= 1'b1;
        rx_byte    <= b;
        byte_kind  <= k;
        byte_typed <= w;
        do
            @(posedge clk);
        while (rx_stall);
    endtask

    // Any byte except the two that steer the parser from every phase.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_ABORT || b == CH_END);
        return b;
    endfunction

    // Mostly number characters, with some stray ones to stop the conversion.
    function automatic logic [7:0] value_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 65)
            return CH_POINT;
        if (r < 73)
            return CH_MINUS;
        if (r < 81)
            return CH_PLUS;
        return plain_byte();
    endfunction

    logic [7:0] packet_bytes[$];

    // Build one random packet: mostly well-formed writes, some queries,
    // broken packets and plain line noise.
    function automatic void build_packet();
        int unsigned shape;
        int unsigned n;
        logic [7:0]  b;
        packet_bytes.delete();
        shape = $urandom_range(0, 99);
        if (shape >= 80)
        begin
            // Line noise: any bytes at all, sometimes closed by '$'.
            n = $urandom_range(1, 6);
            repeat (n) packet_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                packet_bytes.push_back(CH_END);
            return;
        end
        packet_bytes.push_back(CH_START);
        packet_bytes.push_back(plain_byte());
        if (shape >= 72)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    // Non-digit index: discard to '$'.
                    do
                        b = plain_byte();
                    while (b >= CH_ZERO && b <= CH_NINE);
                    packet_bytes.push_back(b);
                end
                1:
                begin
                    // Missing equals sign.
                    packet_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    do
                        b = plain_byte();
                    while (b == CH_EQUALS);
                    packet_bytes.push_back(b);
                end
                2:
                begin
                    // Early '$' at the type, index or equals position.
                    n = $urandom_range(0, 2);
                    if (n == 0)
                        void'(packet_bytes.pop_back());
                    if (n == 2)
                        packet_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    packet_bytes.push_back(CH_END);
                    return;
                end
                default:
                begin
                    // Abort somewhere in the value.
                    packet_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    packet_bytes.push_back(CH_EQUALS);
                    n = $urandom_range(0, 5);
                    repeat (n) packet_bytes.push_back(value_byte());
                    packet_bytes.push_back(CH_ABORT);
                    return;
                end
            endcase
            n = $urandom_range(0, 3);
            repeat (n) packet_bytes.push_back(plain_byte());
            packet_bytes.push_back(CH_END);
            return;
        end
        packet_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        packet_bytes.push_back(CH_EQUALS);
        if (shape >= 65)
        begin
            // Query: no write, rest of the packet dropped.
            packet_bytes.push_back(CH_QUERY);
            n = $urandom_range(0, 3);
            repeat (n) packet_bytes.push_back(plain_byte());
        end
        else
        begin
            // Most values fit the field; some run past it.
            if ($urandom_range(0, 99) < 85)
                n = $urandom_range(0, MAX_VALUE_CHARS);
            else
                n = $urandom_range(MAX_VALUE_CHARS + 1, MAX_VALUE_CHARS + 4);
            repeat (n) packet_bytes.push_back(value_byte());
        end
        packet_bytes.push_back(CH_END);
    endfunction

    // Directed packets. Writes are typed in where the value is plain to see.
    row_t directed_rows[NUM_ROWS];

    initial
    begin
        int unsigned random_words;
        int unsigned next_switch;

        directed_rows = '{
            '{"!W0=$",            ROW_WRITE,   '{4'd0, 28'sd0,        3'd0}},  // empty value
            '{"!A5=99999999$",    ROW_WRITE,   '{4'd5, 28'sd99999999, 3'd0}},  // largest magnitude
            '{"!W9=-99999999$",   ROW_WRITE,   '{4'd9, -28'sd9999999, 3'd0}},  // sign eats a char
            '{"!x3=.1234567$",    ROW_WRITE,   '{4'd3, 28'sd1234567,  3'd7}},  // most fraction digits
            '{"!x6=1234567890$",  ROW_WRITE,   '{4'd6, 28'sd12345678, 3'd0}},  // excess chars
            '{"!x4=-0$",          ROW_WRITE,   '{4'd4, 28'sd0,        3'd0}},  // negative zero
            '{"!x1=-$",           ROW_WRITE,   '{4'd1, 28'sd0,        3'd0}},  // sign only
            '{"!x2=.$",           ROW_WRITE,   '{4'd2, 28'sd0,        3'd0}},  // point only
            '{"!x7=+12.5$",       ROW_WRITE,   '{4'd7, 28'sd125,      3'd1}},
            '{"!x8=12.3.4$",      ROW_WRITE,   '{4'd8, 28'sd123,      3'd1}},  // second point
            '{"!x5=3a9$",         ROW_WRITE,   '{4'd5, 28'sd3,        3'd0}},  // stray letter
            '{"!!1=!4$",          ROW_WRITE,   '{4'd1, 28'sd0,        3'd0}},  // '!' mid-packet
            '{"!x2=1.5-$",        ROW_WRITE,   '{4'd2, 28'sd15,       3'd1}},  // late sign
            '{"!x0=?12$",         ROW_SILENT,  '0},                            // query
            '{"!xa=5$",           ROW_SILENT,  '0},                            // bad index
            '{"!x3:5$",           ROW_SILENT,  '0},                            // no equals
            '{"!x3=12C",          ROW_SILENT,  '0},                            // abort in value
            '{"!x2=7$",           ROW_WRITE,   '{4'd2, 28'sd7,        3'd0}},
            '{"$zz$",             ROW_SILENT,  '0},                            // stray bytes
            '{"!$!x$!x5$",        ROW_SILENT,  '0},                            // early ends
            '{"\377!x1=1$",       ROW_SILENT,  '0},                            // top byte value
            '{"!q7=+.5x$",        ROW_PREDICT, '0},
            '{"!x9=-00012.0$",    ROW_PREDICT, '0},
            '{"!C!x4=-0.0625$",   ROW_PREDICT, '0},                            // abort as type
            '{"!x3=5\377$",       ROW_PREDICT, '0}
        };

        // Hold reset, then release it on an edge.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            for (int i = 0; i < directed_rows[r].text.len(); i++)
                send_byte(directed_rows[r].text[i], directed_rows[r].kind,
                          directed_rows[r].typed);

        // Random stream; switch the idling mix every hundred words or so,
        // and run the tail with both sides flat out.
        random_words = 0;
        next_switch  = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (random_words >= next_switch)
            begin
                idle_pct  = 20 * $urandom_range(0, 2);
                stall_pct <= 20 * $urandom_range(0, 2);
                next_switch += 100;
            end
            if (random_words >= RANDOM_WORDS - CALM_WORDS)
                calm <= 1'b1;
            build_packet();
            foreach (packet_bytes[k])
                send_byte(packet_bytes[k], ROW_PREDICT, '0);
            random_words += packet_bytes.size();
        end

        // Drain: wait for every owed write, then a few more cycles for stragglers.
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending_writes.size() == 0)
            $display("PASS serial_variable_write_parser");
        else
            $display("FAIL serial_variable_write_parser");
        $finish;
    end

endmodule
